@@ rtl/b64l_pkg.sv @@
// Shared types, constants and the symbol lookup for the base64url line encoder.
`timescale 1ns / 1ps

package b64l_pkg;

    localparam int GroupsPerLineDefault = 19;
    localparam int MaxChars             = 6;
    localparam int CharW                = 7;
    localparam int CountW               = 3;

    localparam logic [CharW-1:0] CharCr = 7'd13;
    localparam logic [CharW-1:0] CharLf = 7'd10;

    typedef struct packed {
        logic [MaxChars-1:0][CharW-1:0] chars;
        logic [MaxChars-1:0]            lasts;
        logic [CountW-1:0]              count;
    } b64l_batch_t;

    function automatic logic [CharW-1:0] b64l_sym(input logic [5:0] v);
        logic [CharW-1:0] r;
        if (v < 6'd26) begin
            r = 7'(7'h41 + {1'b0, v});
        end else if (v < 6'd52) begin
            r = 7'(7'h61 + {1'b0, v} - 7'd26);
        end else if (v < 6'd62) begin
            r = 7'(7'h30 + {1'b0, v} - 7'd52);
        end else if (v == 6'd62) begin
            r = 7'h2d;
        end else begin
            r = 7'h5f;
        end
        return r;
    endfunction

endpackage

@@ rtl/b64l_pack.sv @@
// Byte gathering state and per-request character batch generation.
`timescale 1ns / 1ps

module b64l_pack #(
    parameter int GROUPS_PER_LINE = b64l_pkg::GroupsPerLineDefault
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output b64l_pkg::b64l_batch_t batch
);
    import b64l_pkg::*;

    localparam int GilW = $clog2(GROUPS_PER_LINE + 1);

    logic [15:0]     held_reg;
    logic [15:0]     held_next;
    logic [1:0]      held_count_reg;
    logic [1:0]      held_count_next;
    logic [GilW-1:0] gil_reg;
    logic [GilW-1:0] gil_next;
    logic [GilW-1:0] gil_inc;
    logic [23:0]     w;
    logic [7:0]      b0;
    logic            brk;

    always_comb
    begin
        w       = {held_reg, data_byte};
        b0      = held_reg[15:8];
        gil_inc = GilW'(gil_reg + 1'b1);
        brk     = (gil_inc >= GilW'(GROUPS_PER_LINE));

        batch           = '0;
        held_next       = held_reg;
        held_count_next = held_count_reg;
        gil_next        = gil_reg;

        case (held_count_reg)
            2'd2:
            begin
                batch.chars[0] = b64l_sym(w[23:18]);
                batch.chars[1] = b64l_sym(w[17:12]);
                batch.chars[2] = b64l_sym(w[11:6]);
                batch.chars[3] = b64l_sym(w[5:0]);
                batch.lasts[3] = last_byte && !brk;
                if (brk)
                begin
                    batch.chars[4] = CharCr;
                    batch.chars[5] = CharLf;
                    batch.lasts[5] = last_byte;
                    batch.count    = CountW'(6);
                    gil_next       = '0;
                end
                else
                begin
                    batch.count = CountW'(4);
                    gil_next    = gil_inc;
                end
                held_next       = '0;
                held_count_next = 2'd0;
            end
            2'd1:
            begin
                if (last_byte)
                begin
                    batch.chars[0] = b64l_sym(b0[7:2]);
                    batch.chars[1] = b64l_sym({b0[1:0], data_byte[7:4]});
                    batch.chars[2] = b64l_sym({data_byte[3:0], 2'b00});
                    batch.lasts[2] = 1'b1;
                    batch.count    = CountW'(3);
                end
                else
                begin
                    held_next       = {b0, data_byte};
                    held_count_next = 2'd2;
                end
            end
            default:
            begin
                if (last_byte)
                begin
                    batch.chars[0] = b64l_sym(data_byte[7:2]);
                    batch.chars[1] = b64l_sym({data_byte[1:0], 4'b0000});
                    batch.lasts[1] = 1'b1;
                    batch.count    = CountW'(2);
                end
                else
                begin
                    held_next       = {data_byte, 8'h00};
                    held_count_next = 2'd1;
                end
            end
        endcase

        // The end of a message returns all gathering state to its start.
        if (last_byte)
        begin
            held_next       = '0;
            held_count_next = 2'd0;
            gil_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            held_count_reg <= 2'd0;
            gil_reg        <= '0;
        end
        else if (accept)
        begin
            held_reg       <= held_next;
            held_count_reg <= held_count_next;
            gil_reg        <= gil_next;
        end
    end

endmodule

@@ rtl/b64l_emit.sv @@
// Character batch register and one-character-per-cycle output register, held by char_stall.
`timescale 1ns / 1ps

module b64l_emit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  b64l_pkg::b64l_batch_t           batch,
    output logic                            free,
    output logic                            char_valid,
    input  logic                            char_stall,
    output logic [b64l_pkg::CharW-1:0]      out_char,
    output logic                            last_char
);
    import b64l_pkg::*;

    b64l_batch_t       batch_reg;
    logic [CountW-1:0] idx_reg;
    logic              valid_reg;
    logic [CharW-1:0]  char_reg;
    logic              last_reg;
    logic              take;
    logic              pending;
    logic              move;

    always_comb
    begin
        take    = !valid_reg || !char_stall;
        pending = (idx_reg != batch_reg.count);
        move    = pending && take;
        free    = !pending || ((CountW'(idx_reg + 1'b1) == batch_reg.count) && move);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                batch_reg <= batch;
                idx_reg   <= '0;
            end
            else if (move)
            begin
                idx_reg <= CountW'(idx_reg + 1'b1);
            end
            if (take)
            begin
                valid_reg <= move;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            char_reg <= batch_reg.chars[idx_reg];
            last_reg <= batch_reg.lasts[idx_reg];
        end
    end

    assign char_valid = valid_reg;
    assign out_char   = char_reg;
    assign last_char  = last_reg;

endmodule

@@ rtl/base64url_line_encoder.sv @@
// Top level of the unpadded base64url encoder with CR LF line breaks.
//
//   Channel   Fields                 Handshake
//   byte      data_byte, last_byte   byte_valid / byte_stall
//   char      out_char, last_char    char_valid / char_stall
//
// A byte request that yields no characters is taken in any cycle.
// A byte that completes a group or ends a message loads two to six characters
// into the batch register; the output register then gives one per cycle while
// char_stall is low.
// Reset clears the gathering state and empties both registers.
// Output stalls hold the character register and back up into byte_stall.
`timescale 1ns / 1ps

module base64url_line_encoder #(
    parameter int GROUPS_PER_LINE = b64l_pkg::GroupsPerLineDefault
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_valid,
    output logic                       byte_stall,
    input  logic [7:0]                 data_byte,
    input  logic                       last_byte,
    output logic                       char_valid,
    input  logic                       char_stall,
    output logic [b64l_pkg::CharW-1:0] out_char,
    output logic                       last_char
);
    import b64l_pkg::*;

    b64l_batch_t batch;
    logic        accept;
    logic        free;
    logic        load;

    assign byte_stall = !(free || (batch.count == '0));
    assign accept     = byte_valid && !byte_stall;
    assign load       = accept && (batch.count != '0);

    b64l_pack #(
        .GROUPS_PER_LINE(GROUPS_PER_LINE)
    ) u_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .batch    (batch)
    );

    b64l_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .batch     (batch),
        .free      (free),
        .char_valid(char_valid),
        .char_stall(char_stall),
        .out_char  (out_char),
        .last_char (last_char)
    );

endmodule

@@ rtl/b64l_checker.sv @@
// Port-level checks for the base64url line encoder and their binding.
`timescale 1ns / 1ps

module b64l_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       char_valid,
    input logic       char_stall,
    input logic [6:0] out_char,
    input logic       last_char
);

    // A stalled character request holds its payload.
    a_char_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid && $stable(out_char) && $stable(last_char))
        else $error("stalled character changed");

    // Every character is a base64url symbol or part of a line break; no padding.
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (out_char >= 7'h41 && out_char <= 7'h5a) ||
                       (out_char >= 7'h61 && out_char <= 7'h7a) ||
                       (out_char >= 7'h30 && out_char <= 7'h39) ||
                       out_char == 7'h2d || out_char == 7'h5f ||
                       out_char == 7'd13 || out_char == 7'd10)
        else $error("character outside the output alphabet");

    // A message never ends on CR.
    a_no_cr_end: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && out_char == 7'd13 |-> !last_char)
        else $error("message ended on CR");

    // A CR taken by the sink is followed directly by LF.
    a_cr_lf: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_stall && out_char == 7'd13 |=> char_valid && out_char == 7'd10)
        else $error("CR not followed by LF");

endmodule

bind base64url_line_encoder b64l_checker u_b64l_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .out_char  (out_char),
    .last_char (last_char)
);

@@ dv/base64url_line_encoder_test.sv @@
// Testbench for the unpadded base64url line encoder, checked against a built-in predictor.
`timescale 1ns / 1ps

module base64url_line_encoder_test;

    import b64l_pkg::*;

    localparam int    CycleLimit  = 400000;
    localparam string UrlAlphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    typedef struct packed {
        logic [CharW-1:0] ch;
        logic             last;
    } char_exp_t;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             byte_valid = 1'b0;
    logic             byte_stall;
    logic [7:0]       data_byte  = 8'h00;
    logic             last_byte  = 1'b0;
    logic             char_valid;
    logic             char_stall = 1'b0;
    logic [CharW-1:0] out_char;
    logic             last_char;

    char_exp_t   expected_chars[$];
    logic [15:0] pending_bytes = '0;
    logic [1:0]  pending_count = '0;
    logic [4:0]  groups_on_line = '0;

    int error_count  = 0;
    int cycle_count  = 0;
    int max_byte_gap = 9;
    int max_char_gap = 9;
    int char_wait    = 0;
    int bytes_sent   = 0;
    logic sink_hold  = 1'b0;

    base64url_line_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .out_char   (out_char),
        .last_char  (last_char)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [CharW-1:0] url_symbol(input logic [5:0] v);
        return CharW'(UrlAlphabet[int'(v)]);
    endfunction

    function automatic void push_char(input logic [CharW-1:0] c, input logic l);
        char_exp_t e;
        e.ch   = c;
        e.last = l;
        expected_chars.push_back(e);
    endfunction

    // Updates the encoder state for one accepted byte and queues the characters it yields.
    function automatic void encode_byte(input logic [7:0] b, input logic l);
        logic [23:0] w;
        logic [7:0]  b0;
        logic        brk;
        b0 = pending_bytes[15:8];
        if (pending_count == 2'd2)
        begin
            w = {pending_bytes, b};
            groups_on_line = groups_on_line + 5'd1;
            brk = int'(groups_on_line) >= GroupsPerLineDefault;
            push_char(url_symbol(w[23:18]), 1'b0);
            push_char(url_symbol(w[17:12]), 1'b0);
            push_char(url_symbol(w[11:6]), 1'b0);
            push_char(url_symbol(w[5:0]), l && !brk);
            if (brk)
            begin
                groups_on_line = '0;
                push_char(CharCr, 1'b0);
                push_char(CharLf, l);
            end
            pending_bytes = '0;
            pending_count = 2'd0;
        end
        else if (pending_count == 2'd1)
        begin
            if (l)
            begin
                push_char(url_symbol(b0[7:2]), 1'b0);
                push_char(url_symbol({b0[1:0], b[7:4]}), 1'b0);
                push_char(url_symbol({b[3:0], 2'b00}), 1'b1);
            end
            else
            begin
                pending_bytes = {b0, b};
                pending_count = 2'd2;
            end
        end
        else
        begin
            if (l)
            begin
                push_char(url_symbol(b[7:2]), 1'b0);
                push_char(url_symbol({b[1:0], 4'b0000}), 1'b1);
            end
            else
            begin
                pending_bytes = {b, 8'h00};
                pending_count = 2'd1;
            end
        end
        if (l)
        begin
            pending_bytes  = '0;
            pending_count  = 2'd0;
            groups_on_line = '0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = $urandom_range(0, max_byte_gap);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        last_byte  <= l;
        do @(posedge clk); while (byte_stall);
        encode_byte(b, l);
        bytes_sent++;
    endtask

    task automatic send_random_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_byte(8'($urandom), i == len - 1);
        end
    endtask

    task automatic wait_for_drain();
        byte_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
    endtask

    // Output side: each accepted character is compared with the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin : char_sink
            char_exp_t exp_char;
            if (char_valid && !char_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected char %0d", out_char));
                end
                else
                begin
                    exp_char = expected_chars.pop_front();
                    if (out_char !== exp_char.ch)
                        report_mismatch($sformatf("out_char %0d, want %0d",
                                                  out_char, exp_char.ch));
                    if (last_char !== exp_char.last)
                        report_mismatch($sformatf("last_char %0b, want %0b",
                                                  last_char, exp_char.last));
                end
                char_wait = $urandom_range(0, max_char_gap);
            end
            char_stall <= sink_hold || (char_wait > 0);
            if (char_wait > 0)
                char_wait--;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic test_short_messages();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h7E, 1'b1);
    endtask

    // One and two bytes left over after a full line.
    task automatic test_line_breaks();
        send_random_message(GroupsPerLineDefault * 3 + 1);
        send_random_message(GroupsPerLineDefault * 3 + 2);
    endtask

    // The sink holds off long enough that the encoder fills and stalls new requests,
    // while a message that ends on a full line is sent.
    task automatic test_backpressure();
        max_byte_gap = 0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (300) @(posedge clk);
                sink_hold <= 1'b0;
            end
            begin
                send_random_message(GroupsPerLineDefault * 3);
            end
        join
        max_byte_gap = 9;
    endtask

    task automatic test_drain_pause();
        send_random_message(2);
        wait_for_drain();
        send_random_message(1);
    endtask

    task automatic test_random_messages();
        int target;
        int len;
        target = bytes_sent + 8;
        while (bytes_sent < target)
        begin
            len = $urandom_range(1, 8);
            if ($urandom_range(0, 3) == 0)
            begin
                max_byte_gap = 0;
                max_char_gap = 0;
            end
            else
            begin
                max_byte_gap = 9;
                max_char_gap = 9;
            end
            send_random_message(len);
        end
        max_byte_gap = 9;
        max_char_gap = 9;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_messages();
        test_line_breaks();
        test_backpressure();
        test_drain_pause();
        test_random_messages();

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
